### src/dped_pkg.sv
// Shared types and constants for the decimating peak envelope detector.
package dped_pkg;

   // Sample and result field widths
   localparam int SAMPLE_W   = 12;
   localparam int ENV_BYTE_W = 8;
   localparam int BYTE_SHIFT = 4;

   // Configuration register widths
   localparam int DEC_W      = 11;
   localparam int DECAY_W    = 11;
   localparam int MID_W      = 12;
   localparam int LIMIT_W    = 16;
   localparam int CSR_DATA_W = 16;

   // Decay is expressed in 1024ths
   localparam int DECAY_SHIFT = 10;
   localparam int PROD_W      = SAMPLE_W + DECAY_W;

   // Reset values of the configuration registers
   localparam logic [DEC_W-1:0]   DEC_RESET   = DEC_W'(1);
   localparam logic [DECAY_W-1:0] DECAY_RESET = DECAY_W'(1000);
   localparam logic [MID_W-1:0]   MID_RESET   = MID_W'(2048);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(65535);

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_DECIMATION   = 2'd0,
      CSR_DECAY_FACTOR = 2'd1,
      CSR_MID_SCALE    = 2'd2,
      CSR_OUTPUT_LIMIT = 2'd3
   } csr_index_type;

   typedef logic [SAMPLE_W-1:0] sample_type;

endpackage

### src/dped_if.sv
// Request and result channel interfaces of the envelope detector.
interface dped_req_if;
   import dped_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample;
   logic       end_of_block;

   modport source (output valid, sample, end_of_block, input ready);
   modport sink   (input valid, sample, end_of_block, output ready);
endinterface

interface dped_rsp_if;
   import dped_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [ENV_BYTE_W-1:0] envelope_byte;
   sample_type            envelope_full;
   logic                  block_final;

   modport source (output valid, envelope_byte, envelope_full, block_final, input ready);
   modport sink   (input valid, envelope_byte, envelope_full, block_final, output ready);
endinterface

### src/decimating_peak_envelope_detector.sv
// Decimating peak envelope detector: magnitude, window peak, decay, block limit.
//
//   channel   dir  handshake       payload
//   req_chan  in   valid/ready     sample[11:0], end_of_block
//   rsp_chan  out  valid/ready     envelope_byte[7:0], envelope_full[11:0], block_final
//   csr_*     in   csr_we          csr_index[1:0], csr_wdata[15:0]
//
// One request per clock is taken unless a stalled result blocks it; each request passes
// the input register, and one that closes a window then loads the result register.
// The rate is set by the window/envelope update loop.
// Reset is synchronous; config registers return to their defaults, state to zero.
// A stalled result holds the input register, which in turn holds req_chan.ready low.
module decimating_peak_envelope_detector #(
   parameter int MAX_DECIMATION = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   dped_req_if.sink                 req_chan,
   dped_rsp_if.source               rsp_chan,
   input  logic                     csr_we,
   input  dped_pkg::csr_index_type  csr_index,
   input  logic [dped_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dped_pkg::*;

   localparam int FILL_W = (MAX_DECIMATION > 1) ? $clog2(MAX_DECIMATION + 1) : 1;

   // Configuration registers
   logic [DEC_W-1:0]   dec_ff;
   logic [DECAY_W-1:0] decay_ff;
   logic [MID_W-1:0]   mid_ff;
   logic [LIMIT_W-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff   <= DEC_RESET;
         decay_ff <= DECAY_RESET;
         mid_ff   <= MID_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DECIMATION:   dec_ff   <= csr_wdata[DEC_W-1:0];
            CSR_DECAY_FACTOR: decay_ff <= csr_wdata[DECAY_W-1:0];
            CSR_MID_SCALE:    mid_ff   <= csr_wdata[MID_W-1:0];
            CSR_OUTPUT_LIMIT: limit_ff <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register
   logic       s1_valid_ff;
   sample_type s1_sample_ff;
   logic       s1_eob_ff;
   logic       out_free;
   logic       s1_advance;

   assign out_free       = !rsp_chan.valid || rsp_chan.ready;
   assign s1_advance     = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         s1_sample_ff <= req_chan.sample;
         s1_eob_ff    <= req_chan.end_of_block;
      end
   end

   // Window and envelope state
   sample_type          win_max_ff;
   logic [FILL_W-1:0]   win_fill_ff;
   sample_type          held_ff;
   logic [LIMIT_W-1:0]  count_ff;

   // Effective window length: zero means one, clipped at the maximum
   logic [FILL_W-1:0] dec_eff;
   always_comb begin
      if (dec_ff == '0) begin
         dec_eff = FILL_W'(1);
      end else if (32'(dec_ff) > $unsigned(MAX_DECIMATION)) begin
         dec_eff = FILL_W'(MAX_DECIMATION);
      end else begin
         dec_eff = FILL_W'(dec_ff);
      end
   end

   // Per-sample datapath
   logic                  active;
   sample_type            mag;
   sample_type            new_max;
   logic [FILL_W-1:0]     fill_inc;
   logic                  close;
   logic [PROD_W-1:0]     prod;
   logic [PROD_W-DECAY_SHIFT-1:0] scaled;
   sample_type            decayed;
   sample_type            env_next;

   always_comb begin
      active   = count_ff < limit_ff;
      mag      = (s1_sample_ff >= mid_ff) ? (s1_sample_ff - mid_ff) : (mid_ff - s1_sample_ff);
      new_max  = (mag > win_max_ff) ? mag : win_max_ff;
      fill_inc = win_fill_ff + FILL_W'(1);
      close    = active && ((fill_inc >= dec_eff) || s1_eob_ff);
      prod     = PROD_W'(held_ff) * PROD_W'(decay_ff);
      scaled   = prod[PROD_W-1:DECAY_SHIFT];
      // Decay above unity can overflow the sample range: saturate
      decayed  = (|scaled[PROD_W-DECAY_SHIFT-1:SAMPLE_W]) ? '1 : scaled[SAMPLE_W-1:0];
      env_next = (new_max > held_ff) ? new_max : decayed;
   end

   // Next state: window update, close, then end-of-block clear
   sample_type          win_max_in;
   logic [FILL_W-1:0]   win_fill_in;
   sample_type          held_in;
   logic [LIMIT_W-1:0]  count_in;

   always_comb begin
      win_max_in  = win_max_ff;
      win_fill_in = win_fill_ff;
      held_in     = held_ff;
      count_in    = count_ff;
      if (s1_advance) begin
         if (active) begin
            win_max_in  = new_max;
            win_fill_in = fill_inc;
         end
         if (close) begin
            held_in     = env_next;
            count_in    = count_ff + LIMIT_W'(1);
            win_max_in  = '0;
            win_fill_in = '0;
         end
         if (s1_eob_ff) begin
            win_max_in  = '0;
            win_fill_in = '0;
            count_in    = '0;
         end
      end
   end

   // State update
   always_ff @(posedge clock) begin
      if (reset) begin
         win_max_ff  <= '0;
         win_fill_ff <= '0;
         held_ff     <= '0;
         count_ff    <= '0;
      end else begin
         win_max_ff  <= win_max_in;
         win_fill_ff <= win_fill_in;
         held_ff     <= held_in;
         count_ff    <= count_in;
      end
   end

   // Result register
   logic out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_advance && close) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   sample_type out_env_ff;
   logic       out_final_ff;

   always_ff @(posedge clock) begin
      if (s1_advance && close) begin
         out_env_ff   <= env_next;
         out_final_ff <= s1_eob_ff;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.envelope_full = out_env_ff;
   assign rsp_chan.envelope_byte = out_env_ff[BYTE_SHIFT +: ENV_BYTE_W];
   assign rsp_chan.block_final   = out_final_ff;

   // Fill count always wraps before reaching the longest window
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      win_fill_ff < FILL_W'(MAX_DECIMATION))
      else $error("window fill out of range");

   // A result carries the envelope that is then held
   a_env_held: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && close) |=> (rsp_chan.envelope_full == held_ff))
      else $error("result differs from held envelope");

   // End of block clears window and result count
   a_eob_clear: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_eob_ff) |=> (count_ff == '0 && win_fill_ff == '0 && win_max_ff == '0))
      else $error("end of block did not clear state");

   // No result is produced once the block limit is reached
   a_limit: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && !active) |=> (count_ff == '0 || count_ff == $past(count_ff)))
      else $error("result counted past the block limit");

endmodule

### sim/testbench.sv
// Self-checking testbench for the decimating peak envelope detector.
module testbench;
   import dped_pkg::*;

   localparam int CLOCK_PERIOD   = 20;
   localparam int RESET_CYCLES   = 12;
   localparam int MAX_DECIMATION = 1024;
   localparam int NUM_SEGMENTS   = 11;
   localparam int SEG_ITEMS      = 14;
   localparam int HOLD_SEGMENT   = 8;
   localparam int HOLD_CYCLES    = 300;
   localparam int LONG_WINDOW    = 1030;
   localparam int SETTLE_CYCLES  = 8;
   localparam int DRAIN_LIMIT    = 20000;
   localparam int TIMEOUT_CYCLES = 200000;
   localparam int REPORT_LIMIT   = 10;
   localparam logic [PROD_W-1:0] SAMPLE_MAX = PROD_W'((1 << SAMPLE_W) - 1);

   typedef struct packed {
      sample_type code;
      logic       end_of_block;
   } sample_request_type;

   typedef struct packed {
      logic [ENV_BYTE_W-1:0] env_byte;
      sample_type            env_full;
      logic                  block_final;
   } envelope_result_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dped_req_if req_chan ();
   dped_rsp_if rsp_chan ();

   decimating_peak_envelope_detector #(
      .MAX_DECIMATION (MAX_DECIMATION)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Mirror of the configuration registers
   logic [DEC_W-1:0]   cfg_decimation;
   logic [DECAY_W-1:0] cfg_decay;
   logic [MID_W-1:0]   cfg_mid;
   logic [LIMIT_W-1:0] cfg_limit;

   // Predicted detector state
   sample_type         pred_peak;
   logic [DEC_W-1:0]   window_count;
   sample_type         envelope;
   logic [LIMIT_W-1:0] block_results;

   sample_request_type  sample_queue[$];
   envelope_result_type envelope_expected[$];

   int queued_count;
   int accepted_count;
   int result_count;
   int error_count;
   int setting_count;
   int tx_idle_pct;
   int rx_idle_pct;

   // Long receiver hold-off, armed by toggling hold_arm
   logic hold_arm;
   logic hold_seen;
   int   hold_left;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = CSR_DECIMATION;
      csr_wdata         = '0;
      req_chan.valid    = 1'b0;
      req_chan.sample   = '0;
      req_chan.end_of_block = 1'b0;
      rsp_chan.ready    = 1'b0;
      hold_arm          = 1'b0;
   end

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   // Advance the predicted state by one request and queue any result
   function automatic void envelope_step(input sample_type code, input logic eob);
      sample_type          mag;
      logic [DEC_W:0]      dec_eff;
      logic [PROD_W-1:0]   prod;
      logic [PROD_W-1:0]   scaled;
      envelope_result_type res;
      if (block_results < cfg_limit) begin
         mag = (code >= cfg_mid) ? code - cfg_mid : cfg_mid - code;
         if (mag > pred_peak)
            pred_peak = mag;
         window_count = window_count + DEC_W'(1);
         if (cfg_decimation == 0)
            dec_eff = (DEC_W+1)'(1);
         else if (cfg_decimation > MAX_DECIMATION)
            dec_eff = (DEC_W+1)'(MAX_DECIMATION);
         else
            dec_eff = {1'b0, cfg_decimation};
         if (window_count >= dec_eff || eob) begin
            if (pred_peak > envelope) begin
               envelope = pred_peak;
            end else begin
               prod   = PROD_W'(envelope) * PROD_W'(cfg_decay);
               scaled = prod >> DECAY_SHIFT;
               envelope = (scaled > SAMPLE_MAX) ? sample_type'(SAMPLE_MAX)
                                                : scaled[SAMPLE_W-1:0];
            end
            res.env_byte    = envelope[SAMPLE_W-1:BYTE_SHIFT];
            res.env_full    = envelope;
            res.block_final = eob;
            envelope_expected.push_back(res);
            block_results = block_results + LIMIT_W'(1);
            pred_peak     = '0;
            window_count  = '0;
         end
      end
      // end of block always clears the window and the result count
      if (eob) begin
         pred_peak     = '0;
         window_count  = '0;
         block_results = '0;
      end
   endfunction

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            envelope_step(req_chan.sample, req_chan.end_of_block);
            accepted_count++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (sample_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               req_chan.valid        <= 1'b1;
               req_chan.sample       <= sample_queue[0].code;
               req_chan.end_of_block <= sample_queue[0].end_of_block;
               void'(sample_queue.pop_front());
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Hold-off counter
   always @(posedge clock) begin
      if (reset) begin
         hold_seen <= 1'b0;
         hold_left <= 0;
      end else if (hold_arm != hold_seen) begin
         hold_seen <= hold_arm;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Result receiver
   always @(posedge clock) begin
      if (reset)
         rsp_chan.ready <= 1'b0;
      else
         rsp_chan.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
   end

   // Result checker
   always @(posedge clock) begin
      envelope_result_type exp_res;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         result_count++;
         if (envelope_expected.size() == 0) begin
            note_error($sformatf("unexpected result byte=%0d full=%0d final=%0d",
                                 rsp_chan.envelope_byte, rsp_chan.envelope_full,
                                 rsp_chan.block_final));
         end else begin
            exp_res = envelope_expected.pop_front();
            if (rsp_chan.envelope_byte !== exp_res.env_byte ||
                rsp_chan.envelope_full !== exp_res.env_full ||
                rsp_chan.block_final !== exp_res.block_final)
               note_error($sformatf(
                  "result %0d: expected byte=%0d full=%0d final=%0d, got byte=%0d full=%0d final=%0d",
                  result_count, exp_res.env_byte, exp_res.env_full, exp_res.block_final,
                  rsp_chan.envelope_byte, rsp_chan.envelope_full, rsp_chan.block_final));
         end
      end
   end

   task automatic queue_sample(input sample_type code, input logic eob);
      sample_request_type item;
      item.code         = code;
      item.end_of_block = eob;
      sample_queue.push_back(item);
      queued_count++;
   endtask

   // Register write; the mirror follows because the block is idle
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_DECIMATION:   cfg_decimation = value[DEC_W-1:0];
         CSR_DECAY_FACTOR: cfg_decay      = value[DECAY_W-1:0];
         CSR_MID_SCALE:    cfg_mid        = value[MID_W-1:0];
         CSR_OUTPUT_LIMIT: cfg_limit      = value[LIMIT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_setting(input int dec, input int decay, input int mid, input int limit);
      write_reg(CSR_DECIMATION, CSR_DATA_W'(dec));
      write_reg(CSR_DECAY_FACTOR, CSR_DATA_W'(decay));
      write_reg(CSR_MID_SCALE, CSR_DATA_W'(mid));
      write_reg(CSR_OUTPUT_LIMIT, CSR_DATA_W'(limit));
      setting_count++;
   endtask

   // Wait for all requests to be taken and all results to arrive
   task automatic wait_idle();
      int guard;
      guard = 0;
      while ((accepted_count != queued_count || envelope_expected.size() != 0) &&
             guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (accepted_count != queued_count || envelope_expected.size() != 0) begin
         note_error($sformatf("block stalled: %0d requests pending, %0d results missing",
                              queued_count - accepted_count, envelope_expected.size()));
         envelope_expected.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Stimulus
   initial begin : stimulus
      int seg;
      int dec_value;
      int decay_value;
      int mid_value;
      int limit_value;
      int eff_dec;
      int max_block;
      int block_len;
      int seg_items;
      logic open_block;
      logic eob;
      sample_type code;

      queued_count   = 0;
      accepted_count = 0;
      result_count   = 0;
      error_count    = 0;
      setting_count  = 1;
      tx_idle_pct    = 12;
      rx_idle_pct    = 67;
      cfg_decimation = DEC_RESET;
      cfg_decay      = DECAY_RESET;
      cfg_mid        = MID_RESET;
      cfg_limit      = LIMIT_RESET;
      pred_peak      = '0;
      window_count   = '0;
      envelope       = '0;
      block_results  = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: full-scale peaks, mid-scale codes, decay, early block end
      queue_sample(12'd4095, 1'b0);
      queue_sample(12'd0,    1'b0);
      queue_sample(12'd2048, 1'b0);
      queue_sample(12'd2047, 1'b0);
      queue_sample(12'd2049, 1'b0);
      queue_sample(12'd1000, 1'b1);
      queue_sample(12'd3000, 1'b0);
      wait_idle();

      // Zero decimation, decay product saturating, limit reached mid-block
      load_setting(0, 2047, 0, 3);
      queue_sample(12'd4095, 1'b0);
      queue_sample(12'd0,    1'b0);
      queue_sample(12'd0,    1'b0);
      queue_sample(12'd0,    1'b0);
      queue_sample(12'd10,   1'b1);
      queue_sample(12'd5,    1'b0);
      wait_idle();

      // Oversized decimation, zero decay, zero limit drops everything
      load_setting(2047, 0, 4095, 0);
      queue_sample(12'd0,    1'b0);
      queue_sample(12'd4095, 1'b1);
      wait_idle();

      // Window of three, unity decay, single result per block
      load_setting(3, 1024, 2048, 1);
      queue_sample(12'd100,  1'b0);
      queue_sample(12'd4095, 1'b0);
      queue_sample(12'd2048, 1'b0);
      queue_sample(12'd0,    1'b0);
      queue_sample(12'd0,    1'b1);
      queue_sample(12'd2048, 1'b1);
      wait_idle();

      // Random settings with blocks of random content
      for (seg = 0; seg < NUM_SEGMENTS; seg++) begin
         if (seg < 4) begin
            tx_idle_pct = 12;
            rx_idle_pct = 67;
         end else if (seg < 8) begin
            tx_idle_pct = 67;
            rx_idle_pct = 12;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end

         case ($urandom_range(5))
            0:       dec_value = 1;
            1:       dec_value = 2;
            2:       dec_value = $urandom_range(3, 8);
            3:       dec_value = $urandom_range(1, 24);
            4:       dec_value = 0;
            default: dec_value = $urandom_range(1025, 2047);
         endcase
         case ($urandom_range(5))
            0:       decay_value = 0;
            1:       decay_value = 1024;
            2:       decay_value = $urandom_range(900, 1023);
            3:       decay_value = $urandom_range(0, 1024);
            4:       decay_value = $urandom_range(1025, 2047);
            default: decay_value = 1000;
         endcase
         case ($urandom_range(5))
            0:       mid_value = 0;
            1:       mid_value = 4095;
            2:       mid_value = 2048;
            default: mid_value = $urandom_range(0, 4095);
         endcase
         case ($urandom_range(5))
            0:       limit_value = 1;
            1:       limit_value = $urandom_range(2, 4);
            2:       limit_value = 65535;
            3:       limit_value = $urandom_range(1, 65535);
            4:       limit_value = ($urandom_range(2) == 0) ? 0 : 3;
            default: limit_value = $urandom_range(5, 12);
         endcase
         // stall segment: every request gives a result, so the block backs up
         if (seg == HOLD_SEGMENT) begin
            dec_value   = 1;
            limit_value = 65535;
         end
         load_setting(dec_value, decay_value, mid_value, limit_value);

         eff_dec   = (dec_value == 0) ? 1 :
                     (dec_value > MAX_DECIMATION) ? MAX_DECIMATION : dec_value;
         max_block = (eff_dec > 12) ? 40 : 3 * eff_dec + 3;
         seg_items = 0;
         while (seg_items < SEG_ITEMS) begin
            block_len  = $urandom_range(1, max_block);
            open_block = ($urandom_range(9) == 0);
            for (int k = 0; k < block_len; k++) begin
               eob = (k == block_len - 1) && !open_block;
               // occasional stray block end inside a block
               if ($urandom_range(19) == 0)
                  eob = 1'($urandom_range(1));
               case ($urandom_range(11))
                  0:       code = '0;
                  1:       code = '1;
                  2:       code = cfg_mid;
                  3:       code = sample_type'(cfg_mid + 1'b1);
                  4:       code = sample_type'(cfg_mid - 1'b1);
                  default: code = sample_type'($urandom_range(0, 4095));
               endcase
               queue_sample(code, eob);
               seg_items++;
            end
         end
         if (seg == HOLD_SEGMENT)
            hold_arm <= ~hold_arm;
         wait_idle();
      end

      // One window long enough to reach the decimation ceiling
      load_setting(2047, $urandom_range(900, 1023), $urandom_range(0, 4095), 65535);
      for (int k = 0; k < LONG_WINDOW; k++)
         queue_sample(sample_type'($urandom_range(0, 4095)), k == LONG_WINDOW - 1);
      wait_idle();

      $display("Checked %0d envelope results from %0d samples over %0d register settings.",
               result_count, accepted_count, setting_count);
      $display("Run covered decimation and decay limits, block limits and a %0d-cycle stall.",
               HOLD_CYCLES);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("Timeout after %0d cycles", TIMEOUT_CYCLES);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### sim.f
src/dped_pkg.sv
src/dped_if.sv
src/decimating_peak_envelope_detector.sv
sim/testbench.sv
